### rtl/srtn_pkg.sv
// Shared constants, types and codes for the SRTN scheduler.
package srtn_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  localparam int ARR_W = 10;
  localparam int BUR_W = 8;
  localparam int TIME_W = 15;
  localparam int JOB_INDEX_W = 6;
  localparam int NEXT_W = ARR_W + 1;

  localparam logic [NEXT_W-1:0] NEXT_NONE = NEXT_W'(1) << ARR_W;
  localparam int TIME_MAX = (1 << ARR_W) - 1 + MAX_JOBS * ((1 << BUR_W) - 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_STEP,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic load_en;
    logic scan_en;
    logic step_en;
    logic rpt_load;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_last;
    logic step_final;
    logic out_free;
    logic rpt_last;
  } dp_status_t;

endpackage

### rtl/srtn_preemptive_scheduler.sv
// Top level of the shortest-remaining-time-next scheduler.
// A job that does not close the set is only stored; it gives no result.
// A run handles each time unit executed or idle jump by scanning the job store
// one entry per cycle over the n jobs loaded, then stepping.
// Results then leave one per cycle, n in all, while the output is taken.
// Reset clears counters, time and started flags; job stores stay unset.
module srtn_preemptive_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [srtn_pkg::ARR_W-1:0]        arrival_time_i,
  input  logic [srtn_pkg::BUR_W-1:0]        burst_length_i,
  input  logic                              final_job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srtn_pkg::JOB_INDEX_W-1:0]  job_index_o,
  output logic [srtn_pkg::TIME_W-1:0]       finish_time_o,
  output logic [srtn_pkg::TIME_W-1:0]       turnaround_time_o,
  output logic [srtn_pkg::TIME_W-1:0]       wait_time_o,
  output logic [srtn_pkg::TIME_W-1:0]       response_time_o,
  output logic                              last_report_o
);
  import srtn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  srtn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srtn_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .final_job_i       (final_job_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .job_index_o       (job_index_o),
    .finish_time_o     (finish_time_o),
    .turnaround_time_o (turnaround_time_o),
    .wait_time_o       (wait_time_o),
    .response_time_o   (response_time_o),
    .last_report_o     (last_report_o)
  );

endmodule

### rtl/srtn_ctrl.sv
// Controller: sequences load, scan, step and report phases.
module srtn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srtn_pkg::dp_status_t status_i,
  output srtn_pkg::ctrl_cmd_t  cmd_o
);
  import srtn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && status_i.load_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_STEP;
      end
      ST_STEP: begin
        state_d = status_i.step_final ? ST_REPORT : ST_SCAN;
      end
      ST_REPORT: begin
        if (status_i.out_free && status_i.rpt_last) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load_en = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      ST_STEP: begin
        cmd_o.step_en = 1'b1;
      end
      ST_REPORT: begin
        cmd_o.rpt_load = status_i.out_free;
        cmd_o.clear = status_i.out_free && status_i.rpt_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // one phase command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_en, cmd_o.scan_en, cmd_o.step_en, cmd_o.rpt_load}))
    else $error("overlapping phase commands");

  // a finished run always ends in the report phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && status_i.step_final) |=> state_q == ST_REPORT)
    else $error("run end did not enter report");

  // report clear returns to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> in_ready_o)
    else $error("not loading after report");

endmodule

### rtl/srtn_dp.sv
// Datapath: job stores, tick scan, run counters and result register.
module srtn_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  srtn_pkg::ctrl_cmd_t                     cmd_i,
  output srtn_pkg::dp_status_t                    status_o,
  input  logic [srtn_pkg::ARR_W-1:0]              arrival_time_i,
  input  logic [srtn_pkg::BUR_W-1:0]              burst_length_i,
  input  logic                                   final_job_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [srtn_pkg::JOB_INDEX_W-1:0]        job_index_o,
  output logic [srtn_pkg::TIME_W-1:0]             finish_time_o,
  output logic [srtn_pkg::TIME_W-1:0]             turnaround_time_o,
  output logic [srtn_pkg::TIME_W-1:0]             wait_time_o,
  output logic [srtn_pkg::TIME_W-1:0]             response_time_o,
  output logic                                   last_report_o
);
  import srtn_pkg::*;

  logic [ARR_W-1:0]  arrival_q   [MAX_JOBS];
  logic [BUR_W-1:0]  burst_q     [MAX_JOBS];
  logic [BUR_W-1:0]  remaining_q [MAX_JOBS];
  logic [TIME_W-1:0] first_run_q [MAX_JOBS];
  logic [TIME_W-1:0] finish_q    [MAX_JOBS];
  logic [MAX_JOBS-1:0] started_q;

  logic [CNT_W-1:0]  loaded_q, done_q;
  logic [TIME_W-1:0] time_q;
  logic [IDX_W-1:0]  scan_idx_q, rpt_idx_q, pick_q;
  logic              found_q;
  logic [BUR_W-1:0]  best_q;
  logic [NEXT_W-1:0] next_arr_q;

  logic                   out_valid_q;
  logic [JOB_INDEX_W-1:0] job_index_q;
  logic [TIME_W-1:0]      finish_time_q, turnaround_q, wait_q, response_q;
  logic                   last_report_q;

  logic [IDX_W-1:0]  rd_idx, ld_idx;
  logic [ARR_W-1:0]  rd_arr;
  logic [BUR_W-1:0]  rd_bur, rd_rem, rem_dec, ld_bur;
  logic [TIME_W-1:0] rd_first, rd_fin, time_inc, tat, wt, resp;
  logic              rd_started, cand_live, cand_ready, take_best, take_next;

  always_comb begin
    if (cmd_i.step_en) begin
      rd_idx = pick_q;
    end else if (cmd_i.scan_en) begin
      rd_idx = scan_idx_q;
    end else begin
      rd_idx = rpt_idx_q;
    end
  end

  assign ld_idx     = loaded_q[IDX_W-1:0];
  assign ld_bur     = (burst_length_i == '0) ? BUR_W'(1) : burst_length_i;
  assign rd_arr     = arrival_q[rd_idx];
  assign rd_bur     = burst_q[rd_idx];
  assign rd_rem     = remaining_q[rd_idx];
  assign rd_first   = first_run_q[rd_idx];
  assign rd_fin     = finish_q[rd_idx];
  assign rd_started = started_q[rd_idx];

  assign cand_live  = rd_rem != '0;
  assign cand_ready = TIME_W'(rd_arr) <= time_q;
  assign take_best  = cand_live && cand_ready && (!found_q || rd_rem < best_q);
  assign take_next  = cand_live && !cand_ready && (NEXT_W'(rd_arr) < next_arr_q);

  assign rem_dec  = rd_rem - BUR_W'(1);
  assign time_inc = time_q + TIME_W'(1);

  assign tat  = rd_fin - TIME_W'(rd_arr);
  assign wt   = tat - TIME_W'(rd_bur);
  assign resp = rd_first - TIME_W'(rd_arr);

  assign status_o.load_last  = final_job_i || (loaded_q + CNT_W'(1) == CNT_W'(MAX_JOBS));
  assign status_o.scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == loaded_q;
  assign status_o.step_final = found_q && (rd_rem == BUR_W'(1))
                               && (done_q + CNT_W'(1) == loaded_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.rpt_last   = (CNT_W'(rpt_idx_q) + CNT_W'(1)) == loaded_q;

  // run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      done_q      <= '0;
      time_q      <= '0;
      scan_idx_q  <= '0;
      rpt_idx_q   <= '0;
      found_q     <= 1'b0;
      started_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_en) begin
        loaded_q          <= loaded_q + CNT_W'(1);
        started_q[ld_idx] <= 1'b0;
        scan_idx_q        <= '0;
        found_q           <= 1'b0;
      end
      if (cmd_i.scan_en) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        if (take_best) found_q <= 1'b1;
      end
      if (cmd_i.step_en) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        if (found_q) begin
          started_q[pick_q] <= 1'b1;
          time_q <= time_inc;
          if (rem_dec == '0) done_q <= done_q + CNT_W'(1);
        end else begin
          time_q <= TIME_W'(next_arr_q);
        end
      end
      if (cmd_i.rpt_load) begin
        rpt_idx_q   <= rpt_idx_q + IDX_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        loaded_q  <= '0;
        done_q    <= '0;
        time_q    <= '0;
        rpt_idx_q <= '0;
        started_q <= '0;
      end
    end
  end

  // stores, scan payload and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      arrival_q[ld_idx]   <= arrival_time_i;
      burst_q[ld_idx]     <= ld_bur;
      remaining_q[ld_idx] <= ld_bur;
      next_arr_q          <= NEXT_NONE;
    end
    if (cmd_i.scan_en) begin
      if (take_best) begin
        best_q <= rd_rem;
        pick_q <= scan_idx_q;
      end
      if (take_next) next_arr_q <= NEXT_W'(rd_arr);
    end
    if (cmd_i.step_en) begin
      next_arr_q <= NEXT_NONE;
      if (found_q) begin
        remaining_q[pick_q] <= rem_dec;
        if (!rd_started) first_run_q[pick_q] <= time_q;
        if (rem_dec == '0) finish_q[pick_q] <= time_inc;
      end
    end
    if (cmd_i.rpt_load) begin
      job_index_q   <= JOB_INDEX_W'(rpt_idx_q);
      finish_time_q <= rd_fin;
      turnaround_q  <= tat;
      wait_q        <= wt;
      response_q    <= resp;
      last_report_q <= status_o.rpt_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign job_index_o       = job_index_q;
  assign finish_time_o     = finish_time_q;
  assign turnaround_time_o = turnaround_q;
  assign wait_time_o       = wait_q;
  assign response_time_o   = response_q;
  assign last_report_o     = last_report_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("more jobs done than loaded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> CNT_W'(pick_q) < loaded_q)
    else $error("picked job beyond loaded set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(time_q) <= TIME_MAX)
    else $error("time beyond largest finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (loaded_q == '0 && started_q == '0))
    else $error("state not cleared after report");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the SRTN preemptive scheduler: job sets in, per-job reports out.
`timescale 1ns / 1ps

module tb_top;
  import srtn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned RANDOM_JOBS = 420;

  typedef struct {
    logic [JOB_INDEX_W-1:0] index;
    logic [TIME_W-1:0]      finish;
    logic [TIME_W-1:0]      turnaround;
    logic [TIME_W-1:0]      waiting;
    logic [TIME_W-1:0]      response;
    logic                   last_flag;
  } job_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ARR_W-1:0]       arrival_time_i = '0;
  logic [BUR_W-1:0]       burst_length_i = '0;
  logic                   final_job_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [JOB_INDEX_W-1:0] job_index_o;
  logic [TIME_W-1:0]      finish_time_o;
  logic [TIME_W-1:0]      turnaround_time_o;
  logic [TIME_W-1:0]      wait_time_o;
  logic [TIME_W-1:0]      response_time_o;
  logic                   last_report_o;

  // scheduler shadow: jobs of the set being loaded
  logic [ARR_W-1:0]  sched_arrival [MAX_JOBS];
  logic [BUR_W-1:0]  sched_burst [MAX_JOBS];
  int unsigned       loaded_count = 0;
  job_report_t       expected_reports [$];

  int unsigned err_count = 0;
  int unsigned jobs_sent = 0;
  int unsigned sets_run = 0;
  int unsigned reports_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_req = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  srtn_preemptive_scheduler u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .final_job_i       (final_job_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .job_index_o       (job_index_o),
    .finish_time_o     (finish_time_o),
    .turnaround_time_o (turnaround_time_o),
    .wait_time_o       (wait_time_o),
    .response_time_o   (response_time_o),
    .last_report_o     (last_report_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports still pending", cycle_count,
               expected_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Run the whole set to completion, shortest remaining work first.
  function automatic void schedule_set();
    int          remaining [MAX_JOBS];
    int          first_run [MAX_JOBS];
    int          finish [MAX_JOBS];
    int          now;
    int          done;
    int          pick;
    int          next_arrival;
    int          tat;
    job_report_t rpt;
    now = 0;
    done = 0;
    for (int i = 0; i < loaded_count; i++) begin
      remaining[i] = sched_burst[i];
      first_run[i] = -1;
      finish[i] = 0;
    end
    while (done < loaded_count) begin
      pick = -1;
      next_arrival = 1 << 30;
      for (int i = 0; i < loaded_count; i++) begin
        if (remaining[i] == 0) continue;
        if (sched_arrival[i] <= now) begin
          if (pick < 0 || remaining[i] < remaining[pick]) pick = i;
        end else if (sched_arrival[i] < next_arrival) begin
          next_arrival = sched_arrival[i];
        end
      end
      if (pick < 0) begin
        now = next_arrival;
      end else begin
        if (first_run[pick] < 0) first_run[pick] = now;
        remaining[pick]--;
        now++;
        if (remaining[pick] == 0) begin
          finish[pick] = now;
          done++;
        end
      end
    end
    for (int k = 0; k < loaded_count; k++) begin
      tat = finish[k] - sched_arrival[k];
      rpt.index = JOB_INDEX_W'(k);
      rpt.finish = TIME_W'(finish[k]);
      rpt.turnaround = TIME_W'(tat);
      rpt.waiting = TIME_W'(tat - sched_burst[k]);
      rpt.response = TIME_W'(first_run[k] - sched_arrival[k]);
      rpt.last_flag = (k == loaded_count - 1);
      expected_reports.push_back(rpt);
    end
  endfunction

  function automatic void absorb_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                                     input logic fin);
    if (loaded_count < MAX_JOBS) begin
      sched_arrival[loaded_count] = arr;
      sched_burst[loaded_count] = (bur == '0) ? BUR_W'(1) : bur;
      loaded_count++;
    end
    if (fin || loaded_count == MAX_JOBS) begin
      schedule_set();
      loaded_count = 0;
      sets_run++;
    end
  endfunction

  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                          input logic fin);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    arrival_time_i <= arr;
    burst_length_i <= bur;
    final_job_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_job(arr, bur, fin);
    jobs_sent++;
  endtask

  // sender stops offering and waits for every pending report
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : report_check
    job_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual job_index %0d finish %0d",
                 $time, job_index_o, finish_time_o);
        err_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("job_index", want.index, job_index_o);
        check_field("finish_time", want.finish, finish_time_o);
        check_field("turnaround_time", want.turnaround, turnaround_time_o);
        check_field("wait_time", want.waiting, wait_time_o);
        check_field("response_time", want.response, response_time_o);
        check_field("last_report", want.last_flag, last_report_o);
        reports_checked++;
      end
    end
  end

  // receiver: random stall per transfer, or a long hold when requested
  initial begin : rx_driver
    int unsigned stall;
    int unsigned hold;
    wait (rst_ni);
    forever begin
      if (rx_hold_req != 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 18) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic test_single_jobs();
    send_job(10'd1023, 8'd255, 1'b1);
    send_job(10'd0, 8'd1, 1'b1);
  endtask

  task automatic test_preemption();
    // ties on remaining work, a zero burst, and preemption by a shorter arrival
    send_job(10'd0, 8'd8, 1'b0);
    send_job(10'd1, 8'd4, 1'b0);
    send_job(10'd1, 8'd4, 1'b0);
    send_job(10'd3, 8'd2, 1'b0);
    send_job(10'd0, 8'd0, 1'b1);
    // idle stretches between arrivals
    send_job(10'd0, 8'd2, 1'b0);
    send_job(10'd700, 8'd3, 1'b0);
    send_job(10'd300, 8'd1, 1'b1);
  endtask

  task automatic test_full_store();
    for (int j = 0; j < MAX_JOBS; j++) begin
      send_job((j % 2) ? ARR_W'(1023 - j) : ARR_W'(j * 3),
               (j == 0 || j == MAX_JOBS - 1) ? 8'd255 : BUR_W'(j + 1), 1'b0);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle_on = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    for (int s = 0; s < 3; s++) begin
      for (int j = 0; j < 4; j++) begin
        send_job(ARR_W'($urandom_range(0, 5)), BUR_W'($urandom_range(1, 4)), j == 3);
      end
    end
    wait_drained();
    tx_idle_on = 1'b1;
    for (int j = 0; j < 4; j++) begin
      send_job(ARR_W'($urandom_range(0, 30)), BUR_W'($urandom_range(1, 9)), j == 3);
    end
  endtask

  task automatic test_random_sets(input int unsigned job_total);
    int unsigned      sent;
    int unsigned      set_size;
    bit               spread;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic             fin;
    sent = 0;
    while (sent < job_total) begin
      if ($urandom_range(0, 4) == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      set_size = ($urandom_range(0, 9) < 3) ? MAX_JOBS : $urandom_range(1, 8);
      spread = 1'($urandom_range(0, 1));
      for (int j = 0; j < set_size; j++) begin
        arr = spread ? ARR_W'($urandom_range(0, 1023)) : ARR_W'($urandom_range(0, 24));
        bur = ($urandom_range(0, 19) == 0) ? BUR_W'($urandom_range(0, 255))
                                           : BUR_W'($urandom_range(1, 12));
        if (j != set_size - 1) fin = 1'b0;
        else if (set_size == MAX_JOBS) fin = 1'($urandom_range(0, 1));
        else fin = 1'b1;
        send_job(arr, bur, fin);
      end
      sent += set_size;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_jobs();
    test_preemption();
    test_full_store();
    test_backpressure();
    test_random_sets(RANDOM_JOBS);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d job sets from %0d jobs, checked %0d per-job reports", sets_run,
             jobs_sent, reports_checked);
    $display("Covered full-store start, zero bursts, ties, idle gaps, %0d-cycle output hold",
             HOLD_CYCLES);
    if (err_count == 0 && expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/srtn_pkg.sv
rtl/srtn_ctrl.sv
rtl/srtn_dp.sv
rtl/srtn_preemptive_scheduler.sv
dv/tb_top.sv
